FILE: rtl/gewcsr_pkg.sv
// ----------------------------------------------------------------------------
// gewcsr_pkg
// Shared constants, types and codes for the edge weight / CSR builder.
// ----------------------------------------------------------------------------
package gewcsr_pkg;

  localparam int MAX_NEURONS = 1024;
  localparam int MAX_EDGES   = 4096;

  localparam int NODE_W  = 10;
  localparam int COUNT_W = 32;
  localparam int SIGN_W  = 2;
  localparam int POS_W   = 13;
  localparam int EDGE_AW = 12;
  localparam int LIM_W   = 11;
  localparam int MAG_W   = 21;
  localparam int SUM_W   = 33;
  localparam int WGT_W   = 18;
  localparam int FRAC_W  = 16;
  localparam int DIVD_W  = MAG_W + FRAC_W;

  localparam logic [31:0] LN2_Q32 = 32'd2977044471;

  localparam logic [2:0] CMD_LOAD        = 3'd0;
  localparam logic [2:0] CMD_BUILD       = 3'd1;
  localparam logic [2:0] CMD_READ_WEIGHT = 3'd2;
  localparam logic [2:0] CMD_READ_OFFSET = 3'd3;
  localparam logic [2:0] CMD_READ_SORTED = 3'd4;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_RANGE     = 3'd1;
  localparam logic [2:0] ST_FULL      = 3'd2;
  localparam logic [2:0] ST_BAD_POS   = 3'd3;
  localparam logic [2:0] ST_NOT_BUILT = 3'd4;

  localparam logic [1:0] SIGN_EXC = 2'd1;
  localparam logic [1:0] SIGN_INH = 2'd2;

  localparam logic REG_WEIGHT_MODE  = 1'b0;
  localparam logic REG_NEURON_COUNT = 1'b1;

  typedef struct packed {
    logic [NODE_W-1:0]  src;
    logic [NODE_W-1:0]  tgt;
    logic [COUNT_W-1:0] cnt;
    logic [SIGN_W-1:0]  sign;
  } edge_rec_t;

endpackage

FILE: rtl/gewcsr_ram.sv
// ----------------------------------------------------------------------------
// gewcsr_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module gewcsr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: rtl/gewcsr_log1p.sv
// ----------------------------------------------------------------------------
// gewcsr_log1p
// Iterative log1p in unsigned Q5.16: leading-one search one bit a cycle,
// twenty squaring steps for the log2 fraction, then a scale by ln2.
// ----------------------------------------------------------------------------
module gewcsr_log1p
  import gewcsr_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [COUNT_W-1:0] n,
  output logic               busy,
  output logic               done,
  output logic [MAG_W-1:0]   result
);

  typedef enum logic [2:0] {L_IDLE, L_NORM, L_SQ, L_MUL, L_OUT} lstate_t;

  lstate_t       state;
  logic [32:0]   x;
  logic [5:0]    k;
  logic [30:0]   m;
  logic [19:0]   frac;
  logic [4:0]    iter;
  logic [57:0]   prod;
  logic [61:0]   sq_full;
  logic [31:0]   sq;

  assign sq_full = 62'(m) * 62'(m);
  assign sq      = sq_full[61:30];
  assign busy    = (state != L_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= L_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        L_IDLE: begin
          if (start) begin
            x     <= 33'(n) + 33'd1;
            k     <= 6'd32;
            state <= L_NORM;
          end
        end
        L_NORM: begin
          // shift until the leading one sits at the top bit
          if (x[32]) begin
            m     <= x[32:2];
            frac  <= '0;
            iter  <= '0;
            state <= L_SQ;
          end else begin
            x <= {x[31:0], 1'b0};
            k <= k - 6'd1;
          end
        end
        L_SQ: begin
          if (sq[31]) begin
            m    <= sq[31:1];
            frac <= {frac[18:0], 1'b1};
          end else begin
            m    <= sq[30:0];
            frac <= {frac[18:0], 1'b0};
          end
          iter <= iter + 5'd1;
          if (iter == 5'd19) begin
            state <= L_MUL;
          end
        end
        L_MUL: begin
          prod  <= 58'({k, frac}) * 58'(LN2_Q32);
          state <= L_OUT;
        end
        L_OUT: begin
          result <= prod[56:36];
          done   <= 1'b1;
          state  <= L_IDLE;
        end
        default: state <= L_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst) begin
      gewcsr_log_start_idle : assert (!(start && busy))
        else $error("log1p started while busy");
    end
  end

endmodule

FILE: rtl/gewcsr_div.sv
// ----------------------------------------------------------------------------
// gewcsr_div
// Restoring divider, one quotient bit a cycle: (mag << 16) / sum.
// ----------------------------------------------------------------------------
module gewcsr_div
  import gewcsr_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [DIVD_W-1:0] dividend,
  input  logic [SUM_W-1:0]  divisor,
  output logic              done,
  output logic [WGT_W-1:0]  quotient
);

  logic              run;
  logic [5:0]        step;
  logic [SUM_W-1:0]  rem;
  logic [DIVD_W-1:0] quo;
  logic [SUM_W-1:0]  dsr;
  logic [SUM_W:0]    trial;
  logic [SUM_W:0]    diff;

  assign trial    = {rem, quo[DIVD_W-1]};
  assign diff     = trial - {1'b0, dsr};
  assign quotient = quo[WGT_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run  <= 1'b1;
        step <= '0;
        rem  <= '0;
        quo  <= dividend;
        dsr  <= divisor;
      end else if (run) begin
        if (!diff[SUM_W]) begin
          rem <= diff[SUM_W-1:0];
          quo <= {quo[DIVD_W-2:0], 1'b1};
        end else begin
          rem <= trial[SUM_W-1:0];
          quo <= {quo[DIVD_W-2:0], 1'b0};
        end
        step <= step + 6'd1;
        if (step == 6'(DIVD_W - 1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

FILE: rtl/graph_edge_weight_csr_builder_core.sv
// ----------------------------------------------------------------------------
// graph_edge_weight_csr_builder_core
// Edge store with log1p-normalized weights and incoming CSR by counting sort.
//
//   channel  direction  handshake              payload
//   in       to block   in_valid / in_stall    command, nodes, count, sign, pos
//   out      from block out_valid / out_stall  edge_weight_out, index_value,
//                                              status
//   cfg      to block   cfg_write              cfg_index, cfg_data
//
// A load or read item goes through a memory write or registered read, then
// the output register. Build walks the edge store in passes: a check pass,
// a clear sweep of the sum and offset tables, a sum pass (log1p of each
// edge count), a weight pass (log1p, then the 37-step divider, which is
// skipped when the target sum is 0), a prefix pass over the neurons up to
// the neuron count and a scatter pass. Reset is synchronous; no memory is
// cleared by it. One item is in work at a time; a result waits in the
// output register while out_stall is high.
// ----------------------------------------------------------------------------
module graph_edge_weight_csr_builder_core
  import gewcsr_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [2:0]               command,
  input  logic [NODE_W-1:0]        source_node,
  input  logic [NODE_W-1:0]        target_node,
  input  logic [COUNT_W-1:0]       synapse_total,
  input  logic [SIGN_W-1:0]        sign_class,
  input  logic [POS_W-1:0]         read_position,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [WGT_W-1:0]  edge_weight_out,
  output logic [POS_W-1:0]         index_value,
  output logic [2:0]               status,
  input  logic                     cfg_write,
  input  logic                     cfg_index,
  input  logic [LIM_W-1:0]         cfg_data
);

  typedef enum logic [4:0] {
    S_IDLE, S_RESP, B_CHK_RD, B_CHK, B_CLR, E_RD, E_CAP, E_LOG, E_MEM, E_DIV,
    E_WW, E_SCW, P_RD, P_WR
  } state_t;

  typedef enum logic [1:0] {PASS_SUM, PASS_WT, PASS_SC} pass_t;

  state_t               state;
  pass_t                pass;
  logic                 weight_mode;
  logic [LIM_W-1:0]     neuron_count;
  logic [LIM_W-1:0]     lim;
  logic [POS_W-1:0]     edges_loaded;
  logic                 built_flag;
  logic [POS_W-1:0]     e_cnt;
  logic [LIM_W-1:0]     ptr;
  logic [POS_W-1:0]     acc;
  logic [2:0]           cur_cmd;
  logic                 res_mem;
  logic [NODE_W-1:0]    cur_tgt;
  logic [SIGN_W-1:0]    cur_sign;
  logic [MAG_W-1:0]     cur_mag;
  logic [WGT_W-1:0]     cur_q;
  logic [WGT_W-1:0]     res_w;
  logic [POS_W-1:0]     res_idx;
  logic [2:0]           res_st;

  logic                 in_accept;
  logic                 load_ok;
  logic                 out_free;
  logic [WGT_W-1:0]     q_signed;

  // memory ports
  logic                 edge_we, edge_re;
  logic [EDGE_AW-1:0]   edge_raddr;
  edge_rec_t            edge_wrec, edge_rd;
  logic                 wgt_we, wgt_re;
  logic [EDGE_AW-1:0]   wgt_waddr, wgt_raddr;
  logic [WGT_W-1:0]     wgt_wdata, wgt_rd;
  logic                 sum_we, sum_re;
  logic [NODE_W-1:0]    sum_waddr, sum_raddr;
  logic [SUM_W-1:0]     sum_wdata, sum_rd;
  logic                 off_we, off_re;
  logic [LIM_W-1:0]     off_waddr, off_raddr;
  logic [POS_W-1:0]     off_wdata, off_rd;
  logic                 cur_we, cur_re;
  logic [LIM_W-1:0]     cur_waddr, cur_raddr;
  logic [POS_W-1:0]     cur_wdata, cur_rd;
  logic                 srt_we, srt_re;
  logic [EDGE_AW-1:0]   srt_waddr, srt_raddr;
  logic [EDGE_AW-1:0]   srt_wdata, srt_rd;

  logic                 log_start, log_busy, log_done;
  logic [MAG_W-1:0]     log_res;
  logic                 div_start, div_done;
  logic [WGT_W-1:0]     div_q;

  assign lim       = (neuron_count > LIM_W'(MAX_NEURONS)) ? LIM_W'(MAX_NEURONS)
                                                          : neuron_count;
  assign in_stall  = (state != S_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;
  assign load_ok   = ({1'b0, source_node} < lim) && ({1'b0, target_node} < lim)
                     && (edges_loaded < POS_W'(MAX_EDGES));

  always_comb begin
    if (!weight_mode) begin
      q_signed = cur_q;
    end else if (cur_sign == SIGN_EXC) begin
      q_signed = cur_q;
    end else if (cur_sign == SIGN_INH) begin
      q_signed = -cur_q;
    end else begin
      q_signed = '0;
    end
  end

  assign edge_wrec = '{src: source_node, tgt: target_node, cnt: synapse_total,
                       sign: sign_class};

  // memory port steering
  always_comb begin
    edge_we    = 1'b0;
    edge_re    = 1'b0;
    edge_raddr = e_cnt[EDGE_AW-1:0];
    wgt_we     = 1'b0;
    wgt_re     = 1'b0;
    wgt_waddr  = e_cnt[EDGE_AW-1:0];
    wgt_wdata  = q_signed;
    wgt_raddr  = read_position[EDGE_AW-1:0];
    sum_we     = 1'b0;
    sum_re     = 1'b0;
    sum_waddr  = cur_tgt;
    sum_wdata  = sum_rd + SUM_W'(cur_mag);
    sum_raddr  = cur_tgt;
    off_we     = 1'b0;
    off_re     = 1'b0;
    off_waddr  = {1'b0, cur_tgt} + LIM_W'(1);
    off_wdata  = off_rd + POS_W'(1);
    off_raddr  = {1'b0, cur_tgt} + LIM_W'(1);
    cur_we     = 1'b0;
    cur_re     = 1'b0;
    cur_waddr  = {1'b0, cur_tgt};
    cur_wdata  = cur_rd + POS_W'(1);
    cur_raddr  = {1'b0, edge_rd.tgt};
    srt_we     = 1'b0;
    srt_re     = 1'b0;
    srt_waddr  = cur_rd[EDGE_AW-1:0];
    srt_wdata  = e_cnt[EDGE_AW-1:0];
    srt_raddr  = read_position[EDGE_AW-1:0];
    log_start  = 1'b0;
    div_start  = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (in_accept) begin
          edge_we = (command == CMD_LOAD) && load_ok;
          wgt_re  = (command == CMD_READ_WEIGHT);
          srt_re  = (command == CMD_READ_SORTED);
          off_re  = (command == CMD_READ_OFFSET);
          off_raddr = read_position[LIM_W-1:0];
        end
      end
      B_CHK_RD: edge_re = (e_cnt != edges_loaded);
      B_CLR: begin
        sum_we    = !ptr[LIM_W-1];
        sum_waddr = ptr[NODE_W-1:0];
        sum_wdata = '0;
        off_we    = 1'b1;
        off_waddr = ptr;
        off_wdata = '0;
      end
      E_RD: edge_re = (e_cnt != edges_loaded);
      E_CAP: begin
        log_start = (pass != PASS_SC);
        cur_re    = (pass == PASS_SC);
      end
      E_LOG: begin
        if (log_done) begin
          sum_re = 1'b1;
          off_re = (pass == PASS_SUM);
        end
      end
      E_MEM: begin
        if (pass == PASS_SUM) begin
          sum_we = 1'b1;
          off_we = 1'b1;
        end else begin
          div_start = (sum_rd != '0);
        end
      end
      E_WW: wgt_we = 1'b1;
      E_SCW: begin
        srt_we = 1'b1;
        cur_we = 1'b1;
      end
      P_RD: begin
        off_re    = 1'b1;
        off_raddr = ptr;
      end
      P_WR: begin
        off_we    = 1'b1;
        off_waddr = ptr;
        off_wdata = acc + off_rd;
        cur_we    = 1'b1;
        cur_waddr = ptr;
        cur_wdata = acc + off_rd;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      pass         <= PASS_SUM;
      weight_mode  <= 1'b1;
      neuron_count <= LIM_W'(MAX_NEURONS);
      edges_loaded <= '0;
      built_flag   <= 1'b0;
      e_cnt        <= '0;
      out_valid    <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_accept) begin
            cur_cmd <= command;
            res_w   <= '0;
            res_idx <= '0;
            res_st  <= ST_OK;
            res_mem <= 1'b0;
            state   <= S_RESP;
            case (command)
              CMD_LOAD: begin
                if (!(({1'b0, source_node} < lim) && ({1'b0, target_node} < lim))) begin
                  res_st <= ST_RANGE;
                end else if (!load_ok) begin
                  res_st <= ST_FULL;
                end else begin
                  res_idx      <= edges_loaded;
                  edges_loaded <= edges_loaded + POS_W'(1);
                  built_flag   <= 1'b0;
                end
              end
              CMD_BUILD: begin
                e_cnt <= '0;
                state <= B_CHK_RD;
              end
              CMD_READ_WEIGHT, CMD_READ_SORTED: begin
                if (!built_flag) begin
                  res_st <= ST_NOT_BUILT;
                end else if (read_position >= edges_loaded) begin
                  res_st <= ST_BAD_POS;
                end else begin
                  res_mem <= 1'b1;
                end
              end
              CMD_READ_OFFSET: begin
                if (!built_flag) begin
                  res_st <= ST_NOT_BUILT;
                end else if (read_position > POS_W'(lim)) begin
                  res_st <= ST_BAD_POS;
                end else begin
                  res_mem <= 1'b1;
                end
              end
              default: ;
            endcase
          end
        end
        S_RESP: begin
          if (out_free) begin
            out_valid       <= 1'b1;
            status          <= res_st;
            edge_weight_out <= res_w;
            index_value     <= res_idx;
            if (res_mem) begin
              case (cur_cmd)
                CMD_READ_WEIGHT: edge_weight_out <= wgt_rd;
                CMD_READ_OFFSET: index_value <= off_rd;
                default:         index_value <= POS_W'(srt_rd);
              endcase
            end
            state <= S_IDLE;
          end
        end
        B_CHK_RD: begin
          if (e_cnt == edges_loaded) begin
            ptr   <= '0;
            state <= B_CLR;
          end else begin
            state <= B_CHK;
          end
        end
        B_CHK: begin
          if (({1'b0, edge_rd.src} >= lim) || ({1'b0, edge_rd.tgt} >= lim)) begin
            res_st <= ST_RANGE;
            state  <= S_RESP;
          end else begin
            e_cnt <= e_cnt + POS_W'(1);
            state <= B_CHK_RD;
          end
        end
        B_CLR: begin
          ptr <= ptr + LIM_W'(1);
          if (ptr == LIM_W'(MAX_NEURONS)) begin
            e_cnt <= '0;
            pass  <= PASS_SUM;
            state <= E_RD;
          end
        end
        E_RD: begin
          if (e_cnt == edges_loaded) begin
            e_cnt <= '0;
            unique case (pass)
              PASS_SUM: pass <= PASS_WT;
              PASS_WT: begin
                ptr   <= '0;
                acc   <= '0;
                state <= P_RD;
              end
              default: begin
                built_flag <= 1'b1;
                res_st     <= ST_OK;
                state      <= S_RESP;
              end
            endcase
          end else begin
            state <= E_CAP;
          end
        end
        E_CAP: begin
          cur_tgt  <= edge_rd.tgt;
          cur_sign <= edge_rd.sign;
          state    <= (pass == PASS_SC) ? E_SCW : E_LOG;
        end
        E_LOG: begin
          if (log_done) begin
            cur_mag <= log_res;
            state   <= E_MEM;
          end
        end
        E_MEM: begin
          if (pass == PASS_SUM) begin
            e_cnt <= e_cnt + POS_W'(1);
            state <= E_RD;
          end else if (sum_rd == '0) begin
            cur_q <= cur_mag[WGT_W-1:0];
            state <= E_WW;
          end else begin
            state <= E_DIV;
          end
        end
        E_DIV: begin
          if (div_done) begin
            cur_q <= div_q;
            state <= E_WW;
          end
        end
        E_WW: begin
          e_cnt <= e_cnt + POS_W'(1);
          state <= E_RD;
        end
        E_SCW: begin
          e_cnt <= e_cnt + POS_W'(1);
          state <= E_RD;
        end
        P_RD: state <= P_WR;
        P_WR: begin
          acc <= acc + off_rd;
          ptr <= ptr + LIM_W'(1);
          if (ptr == lim) begin
            e_cnt <= '0;
            pass  <= PASS_SC;
            state <= E_RD;
          end else begin
            state <= P_RD;
          end
        end
        default: state <= S_IDLE;
      endcase
      // register writes take priority and drop the built state
      if (cfg_write) begin
        built_flag <= 1'b0;
        unique case (cfg_index)
          REG_WEIGHT_MODE:  weight_mode  <= cfg_data[0];
          REG_NEURON_COUNT: neuron_count <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  gewcsr_ram #(.WIDTH($bits(edge_rec_t)), .DEPTH(MAX_EDGES)) u_edge_ram (
    .clk(clk), .we(edge_we), .waddr(edges_loaded[EDGE_AW-1:0]), .wdata(edge_wrec),
    .re(edge_re), .raddr(edge_raddr), .rdata(edge_rd)
  );

  gewcsr_ram #(.WIDTH(WGT_W), .DEPTH(MAX_EDGES)) u_weight_ram (
    .clk(clk), .we(wgt_we), .waddr(wgt_waddr), .wdata(wgt_wdata),
    .re(wgt_re), .raddr(wgt_raddr), .rdata(wgt_rd)
  );

  gewcsr_ram #(.WIDTH(SUM_W), .DEPTH(MAX_NEURONS)) u_sum_ram (
    .clk(clk), .we(sum_we), .waddr(sum_waddr), .wdata(sum_wdata),
    .re(sum_re), .raddr(sum_raddr), .rdata(sum_rd)
  );

  gewcsr_ram #(.WIDTH(POS_W), .DEPTH(MAX_NEURONS + 1)) u_offset_ram (
    .clk(clk), .we(off_we), .waddr(off_waddr), .wdata(off_wdata),
    .re(off_re), .raddr(off_raddr), .rdata(off_rd)
  );

  gewcsr_ram #(.WIDTH(POS_W), .DEPTH(MAX_NEURONS + 1)) u_cursor_ram (
    .clk(clk), .we(cur_we), .waddr(cur_waddr), .wdata(cur_wdata),
    .re(cur_re), .raddr(cur_raddr), .rdata(cur_rd)
  );

  gewcsr_ram #(.WIDTH(EDGE_AW), .DEPTH(MAX_EDGES)) u_sorted_ram (
    .clk(clk), .we(srt_we), .waddr(srt_waddr), .wdata(srt_wdata),
    .re(srt_re), .raddr(srt_raddr), .rdata(srt_rd)
  );

  gewcsr_log1p u_log1p (
    .clk(clk), .rst(rst), .start(log_start), .n(edge_rd.cnt),
    .busy(log_busy), .done(log_done), .result(log_res)
  );

  gewcsr_div u_div (
    .clk(clk), .rst(rst), .start(div_start), .dividend({cur_mag, FRAC_W'(0)}),
    .divisor(sum_rd), .done(div_done), .quotient(div_q)
  );

  a_store_bound : assert property (@(posedge clk) disable iff (rst)
    edges_loaded <= POS_W'(MAX_EDGES))
    else $error("edge count beyond store size");

  a_cfg_unbuilds : assert property (@(posedge clk) disable iff (rst)
    cfg_write |=> !built_flag)
    else $error("built state survived a register write");

  a_load_advances : assert property (@(posedge clk) disable iff (rst)
    in_accept && command == CMD_LOAD && load_ok
    |=> edges_loaded == $past(edges_loaded) + POS_W'(1))
    else $error("accepted load did not advance the edge count");

  a_walk_bound : assert property (@(posedge clk) disable iff (rst)
    state != S_IDLE && state != S_RESP |-> e_cnt <= edges_loaded)
    else $error("edge walk ran past the loaded edges");

  a_log_idle_start : assert property (@(posedge clk) disable iff (rst)
    log_start |-> !log_busy)
    else $error("log1p unit restarted while busy");

endmodule

FILE: verif/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for graph_edge_weight_csr_builder_core: a directed table
// of edge loads, builds and reads, then random phases under several register
// settings, scored against an in-bench predictor of weights, CSR offsets and
// sorted edge lists or pinned results, with random gaps and output stalls.
// ----------------------------------------------------------------------------
module testbench;
  import gewcsr_pkg::*;

  localparam int IDLE_LIMIT = 300000;
  localparam int EDGE_CAP   = 320;
  localparam int PHASE_LEN  = 190;

  typedef struct {
    logic signed [WGT_W-1:0] w;
    logic [POS_W-1:0]        idx;
    logic [2:0]              st;
  } beat_t;

  typedef struct {
    logic [2:0]         cmd;
    logic [NODE_W-1:0]  src;
    logic [NODE_W-1:0]  tgt;
    logic [COUNT_W-1:0] cnt;
    logic [SIGN_W-1:0]  sgn;
    logic [POS_W-1:0]   pos;
    bit                 pinned;
    beat_t              res;
  } row_t;

  logic clk, rst;
  logic in_valid, in_stall;
  logic [2:0] command;
  logic [NODE_W-1:0] source_node, target_node;
  logic [COUNT_W-1:0] synapse_total;
  logic [SIGN_W-1:0] sign_class;
  logic [POS_W-1:0] read_position;
  logic out_valid, out_stall;
  logic signed [WGT_W-1:0] edge_weight_out;
  logic [POS_W-1:0] index_value;
  logic [2:0] status;
  logic cfg_write, cfg_index;
  logic [LIM_W-1:0] cfg_data;

  graph_edge_weight_csr_builder_core u_top (.*);

  // predictor state
  logic [NODE_W-1:0]  store_src [MAX_EDGES];
  logic [NODE_W-1:0]  store_tgt [MAX_EDGES];
  logic [COUNT_W-1:0] store_cnt [MAX_EDGES];
  logic [SIGN_W-1:0]  store_sgn [MAX_EDGES];
  logic [WGT_W-1:0]   store_wgt [MAX_EDGES];
  logic [SUM_W-1:0]   target_sum [MAX_NEURONS];
  logic [POS_W-1:0]   csr_off [MAX_NEURONS+1];
  logic [POS_W-1:0]   fill_at [MAX_NEURONS+1];
  logic [EDGE_AW-1:0] by_target [MAX_EDGES];
  int  edge_total;
  bit  csr_ready;
  bit  signed_mode;
  logic [LIM_W-1:0] neuron_reg;

  beat_t pending_q[$];
  row_t  rows[$];
  bit    pin_on;
  beat_t pin_res;
  bit    quiet;
  bit    failed;
  int    stall_left, idle_cycles;
  int    n_items, n_results, n_builds;

  function automatic void add_row(row_t r);
    rows.insert(rows.size(), r);
  endfunction

  function automatic int usable();
    return (neuron_reg < MAX_NEURONS) ? int'(neuron_reg) : MAX_NEURONS;
  endfunction

  function automatic logic [31:0] log1p_fx(logic [31:0] n);
    logic [63:0] x, m, prod;
    logic [19:0] frac;
    int k;
    x = 64'(n) + 64'd1;
    k = 0;
    frac = '0;
    while (k < 40 && (x >> (k + 1)) != 0) k++;
    m = (k > 30) ? (x >> (k - 30)) : (x << (30 - k));
    for (int i = 0; i < 20; i++) begin
      m = (m * m) >> 30;
      frac = {frac[18:0], 1'b0};
      if (m >= (64'd1 << 31)) begin
        m = m >> 1;
        frac[0] = 1'b1;
      end
    end
    prod = ((64'(k) << 20) | 64'(frac)) * 64'(LN2_Q32);
    return 32'(prod >> 36);
  endfunction

  function automatic logic [2:0] build_csr();
    int lim;
    logic [63:0] mag, sum, q;
    lim = usable();
    for (int e = 0; e < edge_total; e++)
      if (store_src[e] >= lim || store_tgt[e] >= lim) return ST_RANGE;
    foreach (target_sum[t]) target_sum[t] = '0;
    foreach (csr_off[t]) csr_off[t] = '0;
    for (int e = 0; e < edge_total; e++)
      target_sum[store_tgt[e]] += SUM_W'(log1p_fx(store_cnt[e]));
    for (int e = 0; e < edge_total; e++) begin
      mag = 64'(log1p_fx(store_cnt[e]));
      sum = 64'(target_sum[store_tgt[e]]);
      q = (sum != 0) ? ((mag << 16) / sum) : mag;
      if (signed_mode) begin
        if (store_sgn[e] == SIGN_INH) q = 64'd0 - q;
        else if (store_sgn[e] != SIGN_EXC) q = 0;
      end
      store_wgt[e] = q[WGT_W-1:0];
    end
    for (int e = 0; e < edge_total; e++) csr_off[store_tgt[e] + 1]++;
    for (int t = 1; t <= lim; t++) csr_off[t] += csr_off[t-1];
    fill_at = csr_off;
    for (int e = 0; e < edge_total; e++) begin
      by_target[fill_at[store_tgt[e]]] = EDGE_AW'(e);
      fill_at[store_tgt[e]]++;
    end
    csr_ready = 1;
    return ST_OK;
  endfunction

  function automatic beat_t predict(logic [2:0] cmd, logic [NODE_W-1:0] src,
                                    logic [NODE_W-1:0] tgt, logic [COUNT_W-1:0] cnt,
                                    logic [SIGN_W-1:0] sgn, logic [POS_W-1:0] pos);
    beat_t r;
    int lim;
    r = '{w: '0, idx: '0, st: ST_OK};
    lim = usable();
    case (cmd)
      CMD_LOAD: begin
        if (src >= lim || tgt >= lim) r.st = ST_RANGE;
        else if (edge_total >= MAX_EDGES) r.st = ST_FULL;
        else begin
          store_src[edge_total] = src;
          store_tgt[edge_total] = tgt;
          store_cnt[edge_total] = cnt;
          store_sgn[edge_total] = sgn;
          r.idx = POS_W'(edge_total);
          edge_total++;
          csr_ready = 0;
        end
      end
      CMD_BUILD: begin
        r.st = build_csr();
        if (r.st == ST_OK) n_builds++;
      end
      CMD_READ_WEIGHT, CMD_READ_OFFSET, CMD_READ_SORTED: begin
        if (!csr_ready) r.st = ST_NOT_BUILT;
        else if (cmd == CMD_READ_WEIGHT) begin
          if (pos >= edge_total) r.st = ST_BAD_POS;
          else r.w = store_wgt[pos[EDGE_AW-1:0]];
        end else if (cmd == CMD_READ_OFFSET) begin
          if (pos > lim) r.st = ST_BAD_POS;
          else r.idx = csr_off[pos];
        end else begin
          if (pos >= edge_total) r.st = ST_BAD_POS;
          else r.idx = 13'(by_target[pos[EDGE_AW-1:0]]);
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  // scoreboard, register shadow and watchdog
  always @(posedge clk) begin
    beat_t exp_b, got;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        got = '{w: edge_weight_out, idx: index_value, st: status};
        n_results++;
        if (pending_q.size() == 0) begin
          $error("result beat with nothing expected");
          failed = 1;
        end else begin
          exp_b = pending_q.pop_front();
          if (got.w !== exp_b.w) begin
            $error("edge_weight_out: expected %0d, got %0d", exp_b.w, got.w);
            failed = 1;
          end
          if (got.idx !== exp_b.idx) begin
            $error("index_value: expected %0d, got %0d", exp_b.idx, got.idx);
            failed = 1;
          end
          if (got.st !== exp_b.st) begin
            $error("status: expected %0d, got %0d", exp_b.st, got.st);
            failed = 1;
          end
        end
      end
      if (cfg_write) begin
        if (cfg_index == REG_WEIGHT_MODE) signed_mode = cfg_data[0];
        else neuron_reg = cfg_data;
        csr_ready = 0;
      end
      if (in_valid && !in_stall) begin
        exp_b = predict(command, source_node, target_node, synapse_total,
                        sign_class, read_position);
        pending_q.insert(pending_q.size(), pin_on ? pin_res : exp_b);
        n_items++;
      end
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("graph_edge_weight_csr_builder_core test failed");
        $finish;
      end
    end
  end

  // receiver stalls: mostly short, a few long, none while quiet
  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_stall = 1;
      stall_left--;
    end else begin
      out_stall = 0;
      if (!quiet && $urandom_range(0, 99) < 25)
        stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40)
                                                 : $urandom_range(1, 3);
    end
  end

  task automatic send(row_t r);
    int gap;
    gap = 0;
    if (!quiet && $urandom_range(0, 99) < 40)
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(6, 30) : $urandom_range(1, 3);
    if (gap > 0) begin
      in_valid = 0;
      repeat (gap) @(negedge clk);
    end
    command = r.cmd;
    source_node = r.src;
    target_node = r.tgt;
    synapse_total = r.cnt;
    sign_class = r.sgn;
    read_position = r.pos;
    pin_on = r.pinned;
    pin_res = r.res;
    in_valid = 1;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    pin_on = 0;
  endtask

  task automatic write_reg(logic idx, logic [LIM_W-1:0] val);
    in_valid = 0;
    wait (pending_q.size() == 0);
    repeat (6) @(negedge clk);
    cfg_index = idx;
    cfg_data = val;
    cfg_write = 1;
    @(negedge clk);
    cfg_write = 0;
  endtask

  function automatic logic [NODE_W-1:0] pick_node();
    int lim;
    lim = usable();
    if (lim > 0 && $urandom_range(0, 99) < 88) return NODE_W'($urandom_range(0, lim - 1));
    return NODE_W'($urandom_range(0, MAX_NEURONS - 1));
  endfunction

  function automatic logic [COUNT_W-1:0] pick_count();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return '1;
      2: return $urandom;
      default: return $urandom_range(0, 50);
    endcase
  endfunction

  function automatic row_t random_row();
    row_t r;
    int sel;
    r = '{default: '0};
    sel = $urandom_range(0, 199);
    r.src = NODE_W'($urandom);
    r.tgt = NODE_W'($urandom);
    r.cnt = $urandom;
    r.sgn = SIGN_W'($urandom);
    r.pos = POS_W'($urandom);
    if (sel < 3) r.cmd = CMD_BUILD;
    else if (sel < 6) r.cmd = 3'($urandom_range(5, 7));
    else if (sel < 60 && edge_total < EDGE_CAP) begin
      r.cmd = CMD_LOAD;
      r.src = pick_node();
      r.tgt = pick_node();
      r.cnt = pick_count();
    end else begin
      r.cmd = 3'($urandom_range(CMD_READ_WEIGHT, CMD_READ_SORTED));
      if ($urandom_range(0, 9) != 0)
        r.pos = (r.cmd == CMD_READ_OFFSET) ? POS_W'($urandom_range(0, usable() + 1))
                                           : POS_W'($urandom_range(0, edge_total + 1));
    end
    return r;
  endfunction

  initial begin
    row_t r;
    logic [LIM_W-1:0] counts[6];
    rst = 1;
    in_valid = 0;
    out_stall = 0;
    cfg_write = 0;
    cfg_index = REG_WEIGHT_MODE;
    cfg_data = '0;
    command = CMD_LOAD;
    source_node = '0;
    target_node = '0;
    synapse_total = '0;
    sign_class = '0;
    read_position = '0;
    pin_on = 0;
    quiet = 0;
    failed = 0;
    stall_left = 0;
    idle_cycles = 0;
    edge_total = 0;
    csr_ready = 0;
    signed_mode = 1;
    neuron_reg = 11'd1024;
    n_items = 0;
    n_results = 0;
    n_builds = 0;
    repeat (5) @(negedge clk);
    rst = 0;

    //       cmd              src   tgt   cnt    sgn pos  pin  w idx st
    add_row('{CMD_READ_WEIGHT, 0, 0, 0, 0, 0, 1, '{0, 0, ST_NOT_BUILT}});
    add_row('{CMD_READ_OFFSET, 0, 0, 0, 0, 0, 1, '{0, 0, ST_NOT_BUILT}});
    add_row('{CMD_BUILD, 0, 0, 0, 0, 0, 1, '{0, 0, ST_OK}});
    add_row('{CMD_READ_OFFSET, 0, 0, 0, 0, 1024, 1, '{0, 0, ST_OK}});
    add_row('{CMD_READ_OFFSET, 0, 0, 0, 0, 1025, 1, '{0, 0, ST_BAD_POS}});
    add_row('{CMD_READ_WEIGHT, 0, 0, 0, 0, 0, 1, '{0, 0, ST_BAD_POS}});
    add_row('{CMD_READ_SORTED, 0, 0, 0, 0, 8191, 1, '{0, 0, ST_BAD_POS}});
    add_row('{CMD_LOAD, 1023, 0, 0, SIGN_EXC, 0, 1, '{0, 0, ST_OK}});
    add_row('{CMD_LOAD, 0, 1023, '1, SIGN_INH, 0, 1, '{0, 1, ST_OK}});
    add_row('{CMD_LOAD, 5, 5, 1, 0, 0, 1, '{0, 2, ST_OK}});
    add_row('{CMD_LOAD, 5, 5, 1, 3, 0, 1, '{0, 3, ST_OK}});
    add_row('{CMD_LOAD, 3, 0, 7, SIGN_EXC, 0, 0, '{0, 0, 0}});
    add_row('{3'd5, '1, '1, '1, '1, '1, 1, '{0, 0, ST_OK}});
    add_row('{3'd7, 0, 0, 0, 0, 0, 1, '{0, 0, ST_OK}});
    add_row('{CMD_READ_SORTED, 0, 0, 0, 0, 0, 1, '{0, 0, ST_NOT_BUILT}});
    add_row('{CMD_BUILD, 0, 0, 0, 0, 0, 1, '{0, 0, ST_OK}});
    add_row('{CMD_READ_WEIGHT, 0, 0, 0, 0, 0, 1, '{0, 0, ST_OK}});
    add_row('{CMD_READ_WEIGHT, 0, 0, 0, 0, 1, 1, '{-65536, 0, ST_OK}});
    add_row('{CMD_READ_WEIGHT, 0, 0, 0, 0, 2, 0, '{0, 0, 0}});
    add_row('{CMD_READ_WEIGHT, 0, 0, 0, 0, 3, 0, '{0, 0, 0}});
    add_row('{CMD_READ_WEIGHT, 0, 0, 0, 0, 4, 0, '{0, 0, 0}});
    add_row('{CMD_READ_OFFSET, 0, 0, 0, 0, 1, 0, '{0, 0, 0}});
    add_row('{CMD_READ_OFFSET, 0, 0, 0, 0, 1023, 0, '{0, 0, 0}});
    add_row('{CMD_READ_SORTED, 0, 0, 0, 0, 1, 0, '{0, 0, 0}});
    add_row('{CMD_READ_SORTED, 0, 0, 0, 0, 5, 1, '{0, 0, ST_BAD_POS}});
    foreach (rows[i]) send(rows[i]);

    // register settings per phase; a shrunk count makes stale-endpoint builds fail
    counts = '{11'd1024, 11'd2047, 11'd1, 11'd0, 11'd600, 11'd1024};
    for (int ph = 0; ph < 6; ph++) begin
      write_reg(REG_WEIGHT_MODE, LIM_W'(ph % 2));
      write_reg(REG_NEURON_COUNT, counts[ph]);
      quiet = (ph == 1);
      r = '{default: '0};
      r.cmd = CMD_BUILD;
      send(r);
      for (int i = 0; i < PHASE_LEN; i++) send(random_row());
    end
    quiet = 0;

    // fill the edge store to its limit, then overflow it
    while (edge_total < MAX_EDGES + 3) begin
      r = '{default: '0};
      r.cmd = CMD_LOAD;
      r.src = NODE_W'($urandom);
      r.tgt = NODE_W'($urandom);
      r.cnt = $urandom;
      r.sgn = SIGN_W'($urandom);
      send(r);
      if (edge_total == MAX_EDGES) break;
    end
    for (int i = 0; i < 3; i++) begin
      r.pinned = 1;
      r.res = '{0, 0, ST_FULL};
      send(r);
    end
    r = '{default: '0};
    r.cmd = CMD_READ_WEIGHT;
    send(r);

    in_valid = 0;
    wait (pending_q.size() == 0);
    repeat (20) @(negedge clk);
    $display("Covered %0d items and %0d results, %0d successful builds, %0d edges stored.",
             n_items, n_results, n_builds, edge_total);
    $display("Both weight modes, neuron counts 0 to 2047, a full store and random stalls.");
    if (!failed && pending_q.size() == 0)
      $display("graph_edge_weight_csr_builder_core test passed");
    else
      $display("graph_edge_weight_csr_builder_core test failed");
    $finish;
  end

endmodule

FILE: graph_edge_weight_csr_builder_core.f
rtl/gewcsr_pkg.sv
rtl/gewcsr_ram.sv
rtl/gewcsr_log1p.sv
rtl/gewcsr_div.sv
rtl/graph_edge_weight_csr_builder_core.sv
verif/testbench.sv
